// ===== design/spm_pkg.sv =====
// Shared types and constants of the sparse polynomial multiplier.
// Used by spm_term_mem, spm_mac and sparse_polynomial_multiplier_unit.
// No dependencies.
package spm_pkg;

  // Default sizing
  localparam int MAX_TERMS_DEF    = 64;
  localparam int MAX_EXPONENT_DEF = 31;

  // Fixed field widths
  localparam int COEF_W  = 16;
  localparam int EXP_W   = 5;
  localparam int SUM_W   = 6;
  localparam int ACC_W   = 48;
  localparam int PROD_W  = 2 * COEF_W;
  localparam int EXP_LIM = (1 << EXP_W) - 1;

  // Command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_APPLY  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_ADD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FLUSH
  } spm_state_t;

  // Control of the multiply-accumulate unit
  typedef struct packed {
    logic             rd_en;
    logic [SUM_W-1:0] rd_addr;
    logic             mul_en;
    logic             wr_en;
    logic [SUM_W-1:0] wr_addr;
    logic             clr;
  } acc_ctl_t;

endpackage

// ===== design/sparse_polynomial_multiplier_unit.sv =====
// Sparse polynomial multiplier top level: sequencer, counters, result register.
// Instantiates spm_term_mem and spm_mac; depends on spm_pkg.
//
//  channel  | ports                 | contents (lowest bit first)
//  ---------+-----------------------+-----------------------------------------
//  input    | in_tvalid/in_tready   | tdata: coefficient[15:0], exponent[20:16]
//           |                       | tuser: command[1:0]
//  result   | out_tvalid/out_tready | tdata: product_coefficient[47:0],
//           |                       |        product_exponent[53:48]
//           |                       | tuser: is_empty, terms_dropped; tlast: is_last
//
// Load and dropped items are accepted in the idle state. An apply walks the N
// stored terms: fetch, multiply plus accumulator read, add plus write-back,
// all through the one multiplier and adder. A finish scans the accumulators
// top down, a read and a check per entry, then a flush, and stalls while the
// result register is full. Reset clears counters and accumulator valid bits;
// no clearing pass.
module sparse_polynomial_multiplier_unit #(
  parameter int MAX_TERMS    = spm_pkg::MAX_TERMS_DEF,
  parameter int MAX_EXPONENT = spm_pkg::MAX_EXPONENT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // coefficient[15:0], exponent[20:16], zero pad
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // product_coefficient[47:0], product_exponent[53:48]
  output logic [1:0]  out_tuser,  // is_empty[0], terms_dropped[1]
  output logic        out_tlast   // is_last
);
  import spm_pkg::*;

  localparam int TW        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW        = $clog2(MAX_TERMS + 1);
  localparam int EXP_MAX   = (MAX_EXPONENT < EXP_LIM) ? MAX_EXPONENT : EXP_LIM;
  localparam int ACC_DEPTH = 2 * EXP_MAX + 1;
  localparam int AW        = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam logic [CW-1:0]    CNT_FULL = CW'(MAX_TERMS);
  localparam logic [SUM_W-1:0] ACC_TOP  = SUM_W'(ACC_DEPTH - 1);
  localparam logic [EXP_W-1:0] EXP_TOP  = EXP_W'(EXP_MAX);

  // Input fields
  logic [1:0]               in_cmd;
  logic signed [COEF_W-1:0] in_coef;
  logic [EXP_W-1:0]         in_exp;
  logic                     in_xfer;
  logic                     exp_bad;

  assign in_cmd  = in_tuser;
  assign in_coef = in_tdata[COEF_W-1:0];
  assign in_exp  = in_tdata[COEF_W+EXP_W-1:COEF_W];
  assign in_xfer = in_tvalid && in_tready;
  assign exp_bad = (in_exp > EXP_TOP);

  // State and datapath registers
  spm_state_t               state_r, state_nxt;
  logic [CW-1:0]            first_cnt_r;
  logic [CW-1:0]            second_cnt_r;
  logic [CW-1:0]            t_r;
  logic [SUM_W-1:0]         e_r;
  logic [SUM_W-1:0]         sum_r;
  logic signed [COEF_W-1:0] coef_r;
  logic [EXP_W-1:0]         exp_r;
  logic                     dropped_r;
  logic                     pend_v_r;
  logic [ACC_W-1:0]         pend_coef_r;
  logic [SUM_W-1:0]         pend_exp_r;
  logic                     out_valid_r;
  logic [ACC_W-1:0]         out_coef_r;
  logic [SUM_W-1:0]         out_exp_r;
  logic                     out_empty_r;
  logic                     out_drop_r;
  logic                     out_last_r;

  // Term memory and shared unit
  logic [COEF_W-1:0] term_coef;
  logic [EXP_W-1:0]  term_exp;
  logic              term_wr;
  logic              term_rd;
  logic [SUM_W-1:0]  exp_sum;
  logic [ACC_W-1:0]  acc_val;
  acc_ctl_t          acc_ctl;

  // Sequencer side signals
  logic load_ok;
  logic apply_ok;
  logic out_free;
  logic acc_nz;
  logic scan_stall;
  logic out_load;
  logic term_done;
  logic scan_done;

  assign out_free  = !out_valid_r || out_tready;
  assign acc_nz    = (acc_val != '0);
  assign exp_sum   = {1'b0, term_exp} + {1'b0, exp_r};
  assign term_done = (t_r + CW'(1) == first_cnt_r);
  assign scan_done = (e_r == '0);
  assign load_ok   = (first_cnt_r != CNT_FULL) && !exp_bad;
  assign apply_ok  = (second_cnt_r != CNT_FULL) && !exp_bad;

  spm_term_mem #(
    .DEPTH (MAX_TERMS),
    .AW    (TW)
  ) u_term_mem (
    .clk     (clk),
    .wr_en   (term_wr),
    .wr_addr (first_cnt_r[TW-1:0]),
    .wr_coef (in_coef),
    .wr_exp  (in_exp),
    .rd_en   (term_rd),
    .rd_addr (t_r[TW-1:0]),
    .rd_coef (term_coef),
    .rd_exp  (term_exp)
  );

  spm_mac #(
    .DEPTH (ACC_DEPTH),
    .AW    (AW)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl),
    .op_a    (coef_r),
    .op_b    (term_coef),
    .acc_val (acc_val)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_cmd == CMD_APPLY && apply_ok && first_cnt_r != '0) begin
            state_nxt = ST_FETCH;
          end else if (in_cmd == CMD_FINISH) begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_FETCH:    state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_ADD;
      ST_ADD:      state_nxt = term_done ? ST_IDLE : ST_FETCH;
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (!scan_stall) begin
          state_nxt = scan_done ? ST_FLUSH : ST_SCAN_RD;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready       = 1'b0;
    term_wr         = 1'b0;
    term_rd         = 1'b0;
    scan_stall      = 1'b0;
    out_load        = 1'b0;
    acc_ctl         = '0;
    acc_ctl.wr_addr = sum_r;
    acc_ctl.rd_addr = e_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        term_wr   = in_tvalid && (in_cmd == CMD_LOAD) && load_ok;
      end
      ST_FETCH: begin
        term_rd = 1'b1;
      end
      ST_MUL: begin
        acc_ctl.mul_en  = 1'b1;
        acc_ctl.rd_en   = 1'b1;
        acc_ctl.rd_addr = exp_sum;
      end
      ST_ADD: begin
        acc_ctl.wr_en = 1'b1;
      end
      ST_SCAN_RD: begin
        acc_ctl.rd_en = 1'b1;
      end
      ST_SCAN_CHK: begin
        scan_stall = acc_nz && pend_v_r && !out_free;
        out_load   = acc_nz && pend_v_r && out_free;
      end
      ST_FLUSH: begin
        out_load    = out_free;
        acc_ctl.clr = out_free;
      end
      default: ;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Counters, flags and the pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      dropped_r    <= 1'b0;
      pend_v_r     <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_cmd == CMD_LOAD) begin
            if (load_ok) begin
              first_cnt_r <= first_cnt_r + CW'(1);
            end else begin
              dropped_r <= 1'b1;
            end
          end else if (in_tvalid && in_cmd == CMD_APPLY) begin
            if (apply_ok) begin
              second_cnt_r <= second_cnt_r + CW'(1);
            end else begin
              dropped_r <= 1'b1;
            end
          end
        end
        ST_SCAN_CHK: begin
          if (acc_nz && !scan_stall) begin
            pend_v_r <= 1'b1;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            first_cnt_r  <= '0;
            second_cnt_r <= '0;
            dropped_r    <= 1'b0;
            pend_v_r     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Operand capture, term index, scan index and pending payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      coef_r <= in_coef;
      exp_r  <= in_exp;
      t_r    <= '0;
      e_r    <= ACC_TOP;
    end
    if (state_r == ST_MUL) begin
      sum_r <= exp_sum;
    end
    if (state_r == ST_ADD) begin
      t_r <= t_r + CW'(1);
    end
    if (state_r == ST_SCAN_CHK && !scan_stall) begin
      e_r <= e_r - SUM_W'(1);
      if (acc_nz) begin
        pend_coef_r <= acc_val;
        pend_exp_r  <= e_r;
      end
    end
  end

  // Result register: load the pending term or an empty term, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drop_r <= dropped_r;
      if (state_r == ST_FLUSH && !pend_v_r) begin
        out_coef_r  <= '0;
        out_exp_r   <= '0;
        out_empty_r <= 1'b1;
        out_last_r  <= 1'b1;
      end else begin
        out_coef_r  <= pend_coef_r;
        out_exp_r   <= pend_exp_r;
        out_empty_r <= 1'b0;
        out_last_r  <= (state_r == ST_FLUSH);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_exp_r, out_coef_r};
  assign out_tuser  = {out_drop_r, out_empty_r};
  assign out_tlast  = out_last_r;

  // A result is loaded only into a free register
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // Neither term count ever exceeds its capacity
  a_first_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (first_cnt_r <= CNT_FULL) && (second_cnt_r <= CNT_FULL))
    else $error("term count out of range");

  // The term walk stays within the stored terms
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_ADD) |-> (t_r < first_cnt_r))
    else $error("term index past stored terms");

  // Finishing clears counts and the dropped flag
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_free) |=>
      (first_cnt_r == '0 && second_cnt_r == '0 && !dropped_r && !pend_v_r))
    else $error("state not cleared after finish");

  // A finish run ends with the last flag on the loaded result
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_free) |=> (out_tvalid && out_tlast))
    else $error("finish run without last result");

endmodule

// ===== design/spm_term_mem.sv =====
// Term list memory: stores first-list coefficient and exponent pairs.
// One write port, one registered read port. Depends on spm_pkg.
module spm_term_mem #(
  parameter int DEPTH = spm_pkg::MAX_TERMS_DEF,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [spm_pkg::COEF_W-1:0] wr_coef,
  input  logic [spm_pkg::EXP_W-1:0]  wr_exp,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [spm_pkg::COEF_W-1:0] rd_coef,
  output logic [spm_pkg::EXP_W-1:0]  rd_exp
);
  import spm_pkg::*;

  logic [COEF_W+EXP_W-1:0] mem [DEPTH];
  logic [COEF_W+EXP_W-1:0] rd_data_r;

  // Write a term; the read of a term is registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_exp, wr_coef};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_coef = rd_data_r[COEF_W-1:0];
  assign rd_exp  = rd_data_r[COEF_W+EXP_W-1:COEF_W];

endmodule

// ===== design/spm_mac.sv =====
// Shared multiply-accumulate unit: one 16x16 multiplier, one 48-bit adder
// and the accumulator memory with per-entry valid bits. Depends on spm_pkg.
module spm_mac #(
  parameter int DEPTH = 2 * spm_pkg::MAX_EXPONENT_DEF + 1,
  parameter int AW    = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spm_pkg::acc_ctl_t                 ctl,
  input  logic signed [spm_pkg::COEF_W-1:0] op_a,
  input  logic signed [spm_pkg::COEF_W-1:0] op_b,
  output logic [spm_pkg::ACC_W-1:0]         acc_val
);
  import spm_pkg::*;

  logic [ACC_W-1:0]         acc_mem [DEPTH];
  logic [DEPTH-1:0]         vld_r;
  logic [ACC_W-1:0]         rd_data_r;
  logic                     rd_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]         sum;

  // Entries never written since the last clear read as zero
  assign acc_val = rd_vld_r ? rd_data_r : '0;
  assign sum     = acc_val + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // Multiply, read and write back the accumulator
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (ctl.rd_en) begin
      rd_data_r <= acc_mem[ctl.rd_addr[AW-1:0]];
      rd_vld_r  <= vld_r[ctl.rd_addr[AW-1:0]];
    end
    if (ctl.wr_en) begin
      acc_mem[ctl.wr_addr[AW-1:0]] <= sum;
    end
  end

  // Valid bits: set on write, drop all on clear
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[ctl.wr_addr[AW-1:0]] <= 1'b1;
    end
  end

endmodule

// ===== dv/sparse_polynomial_multiplier_unit_test.sv =====
// Self-checking testbench for sparse_polynomial_multiplier_unit: directed and random
// term streams with random idling on both channels, checked against an in-bench model.
// Depends on spm_pkg and the design files under design/.
module sparse_polynomial_multiplier_unit_test;
  import spm_pkg::*;

  localparam int MAX_TERMS    = MAX_TERMS_DEF;
  localparam int MAX_EXPONENT = MAX_EXPONENT_DEF;
  localparam int ACC_DEPTH    = 2 * MAX_EXPONENT + 1;
  localparam int TERM_TARGET  = 320;
  localparam int SETTLE_CYCLES = 400;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACC_W-1:0] coef;
    logic [SUM_W-1:0] expo;
    logic             is_empty;
    logic             dropped;
    logic             is_last;
  } product_term_t;

  // Tracks stored P terms and exponent accumulators; queues expected output terms
  class spm_product_tracker;
    logic signed [COEF_W-1:0] p_coef [MAX_TERMS];
    logic [EXP_W-1:0]         p_exp  [MAX_TERMS];
    int unsigned              p_count;
    int unsigned              q_count;
    logic [ACC_W-1:0]         acc [ACC_DEPTH];
    bit                       dropped;
    product_term_t            expected_terms [$];
    int unsigned              errors;

    function new();
      errors = 0;
      clear_product();
    endfunction

    function void clear_product();
      p_count = 0;
      q_count = 0;
      dropped = 0;
      foreach (acc[e]) acc[e] = '0;
    endfunction

    function int pending();
      return expected_terms.size();
    endfunction

    // Update the model with one accepted input transfer
    function void note_term(logic [1:0] cmd, logic signed [COEF_W-1:0] coef,
                            logic [EXP_W-1:0] expo);
      product_term_t t;
      int            e;
      int            s;
      int unsigned   n_out;
      longint        prod;
      case (cmd)
        CMD_LOAD: begin
          if (p_count >= MAX_TERMS || expo > MAX_EXPONENT) begin
            dropped = 1;
          end else begin
            p_coef[p_count] = coef;
            p_exp[p_count]  = expo;
            p_count++;
          end
        end
        CMD_APPLY: begin
          if (q_count >= MAX_TERMS || expo > MAX_EXPONENT) begin
            dropped = 1;
          end else begin
            q_count++;
            for (int k = 0; k < p_count; k++) begin
              s    = int'(p_exp[k]) + int'(expo);
              prod = longint'(p_coef[k]) * longint'(coef);
              if (s < ACC_DEPTH) acc[s] = acc[s] + prod[ACC_W-1:0];
            end
          end
        end
        CMD_FINISH: begin
          n_out = 0;
          for (e = ACC_DEPTH - 1; e >= 0; e--) begin
            if (acc[e] != '0) begin
              t.coef     = acc[e];
              t.expo     = SUM_W'(e);
              t.is_empty = 1'b0;
              t.dropped  = dropped;
              t.is_last  = 1'b0;
              expected_terms.push_back(t);
              n_out++;
            end
          end
          if (n_out == 0) begin
            t.coef     = '0;
            t.expo     = '0;
            t.is_empty = 1'b1;
            t.dropped  = dropped;
            t.is_last  = 1'b1;
            expected_terms.push_back(t);
          end else begin
            expected_terms[$].is_last = 1'b1;
          end
          clear_product();
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted output transfer with the oldest expected term
    function void check_term(product_term_t got);
      product_term_t want;
      if (expected_terms.size() == 0) begin
        $error("output term with none expected: coefficient %0d exponent %0d",
               $signed(got.coef), got.expo);
        errors++;
        return;
      end
      want = expected_terms.pop_front();
      if (got.coef !== want.coef) begin
        $error("product_coefficient: expected %0d, actual %0d",
               $signed(want.coef), $signed(got.coef));
        errors++;
      end
      if (got.expo !== want.expo) begin
        $error("product_exponent: expected %0d, actual %0d", want.expo, got.expo);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0b, actual %0b", want.is_empty, got.is_empty);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("terms_dropped: expected %0b, actual %0b", want.dropped, got.dropped);
        errors++;
      end
      if (got.is_last !== want.is_last) begin
        $error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  spm_product_tracker tracker = new();
  int unsigned        idle_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        terms_sent = 0;

  sparse_polynomial_multiplier_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check output transfers and stall the result channel at random
  always @(posedge clk) begin
    product_term_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.coef     = out_tdata[47:0];
      got.expo     = out_tdata[53:48];
      got.is_empty = out_tuser[0];
      got.dropped  = out_tuser[1];
      got.is_last  = out_tlast;
      tracker.check_term(got);
    end
    out_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // Present one term, idling first at random, and hold it until the transfer
  task automatic send_term(logic [1:0] cmd, logic signed [COEF_W-1:0] coef,
                           logic [EXP_W-1:0] expo);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, expo, coef};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    tracker.note_term(cmd, coef, expo);
    if (cmd != CMD_UNUSED) terms_sent++;
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef(bit narrow);
    int v;
    if (narrow) begin
      v = int'($urandom_range(6, 0)) - 3;
      return COEF_W'(v);
    end
    case ($urandom_range(15, 0))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [EXP_W-1:0] rand_expo(bit narrow);
    return narrow ? EXP_W'($urandom_range(3, 0)) : EXP_W'($urandom_range(31, 0));
  endfunction

  // One product: loads and applies (loads first, or interleaved), with noise, then finish
  task automatic run_product(int n_load, int n_apply, bit narrow, bit mixed);
    int loads_left;
    int applies_left;
    bit pick_load;
    loads_left   = n_load;
    applies_left = n_apply;
    while (loads_left + applies_left > 0) begin
      if ($urandom_range(9, 0) == 0)
        send_term(CMD_UNUSED, COEF_W'($urandom), EXP_W'($urandom));
      if (loads_left == 0)        pick_load = 1'b0;
      else if (applies_left == 0) pick_load = 1'b1;
      else if (mixed)             pick_load = $urandom_range(1, 0);
      else                        pick_load = 1'b1;
      send_term(pick_load ? CMD_LOAD : CMD_APPLY, rand_coef(narrow), rand_expo(narrow));
      if (pick_load) loads_left--;
      else           applies_left--;
    end
    send_term(CMD_FINISH, COEF_W'($urandom), EXP_W'($urandom));
  endtask

  // Hold the sender until every expected term has been received
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  initial begin
    int seq;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Finish with nothing loaded: one empty term
    send_term(CMD_FINISH, 16'sh1234, 5'd17);
    // Extreme coefficients and exponents, an ignored command, a load after an apply
    send_term(CMD_LOAD, 16'sh8000, 5'd31);
    send_term(CMD_LOAD, 16'sh7FFF, 5'd0);
    send_term(CMD_APPLY, 16'sh8000, 5'd31);
    send_term(CMD_UNUSED, 16'shFFFF, 5'd31);
    send_term(CMD_APPLY, 16'sh7FFF, 5'd0);
    send_term(CMD_LOAD, 16'sd5, 5'd3);
    send_term(CMD_APPLY, -16'sd1, 5'd2);
    send_term(CMD_FINISH, 16'sh0000, 5'd0);
    // Like terms that cancel to an empty product
    send_term(CMD_LOAD, 16'sd2, 5'd4);
    send_term(CMD_APPLY, 16'sd3, 5'd1);
    send_term(CMD_APPLY, -16'sd3, 5'd1);
    send_term(CMD_FINISH, 16'shFFFF, 5'd31);
    // Zero coefficient term
    send_term(CMD_LOAD, 16'sd0, 5'd7);
    send_term(CMD_APPLY, 16'sh8000, 5'd7);
    send_term(CMD_FINISH, 16'sh0000, 5'd0);
    // Single term at exponent zero
    send_term(CMD_LOAD, -16'sd1, 5'd0);
    send_term(CMD_APPLY, -16'sd1, 5'd0);
    send_term(CMD_FINISH, 16'sh5555, 5'd10);

    // Overfill both lists so terms get dropped and flagged
    drain_results();
    run_product(MAX_TERMS + 2, MAX_TERMS + 2, 1'b0, 1'b0);

    // Random products, cycling through idle and stall phases
    seq = 0;
    while (terms_sent < TERM_TARGET) begin
      seq++;
      case (seq % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      if (seq % 3 == 0) drain_results();
      run_product(($urandom_range(7, 0) == 0) ? $urandom_range(40, 0) : $urandom_range(10, 0),
                  $urandom_range(10, 0), $urandom_range(2, 0) == 0,
                  $urandom_range(3, 0) == 0);
    end
    in_tvalid <= 1'b0;

    // Wait for outstanding terms, then let the block settle
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Stop a hung run
  initial begin
    #10000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
design/spm_pkg.sv
design/spm_term_mem.sv
design/spm_mac.sv
design/sparse_polynomial_multiplier_unit.sv
dv/sparse_polynomial_multiplier_unit_test.sv
